>>> sv/assert_macros.svh
// assertion helpers, clocked on clock and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SBP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define SBP_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> sv/sbp_pkg.sv
package sbp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DIMENSIONS = 3;
   localparam int IDXW       = $clog2(DIMENSIONS);

   // offset magnitude, distance and norm widths
   localparam int VW    = 33;
   localparam int DW    = 33;
   localparam int SW    = 2 * VW;
   localparam int RW    = DW + 3;
   // shift-add multiplier: wide multiplicand, serial multiplier
   localparam int MBW   = 33;
   localparam int MAW   = 2 * DW - FRAC_BITS + 32;
   localparam int PW    = MAW + MBW;
   localparam int BASEW = DW + 64 - 2 * FRAC_BITS;
   localparam int NUMW  = BASEW + VW;
   localparam int QW    = 33;
   localparam int ESW   = 63;

   localparam int MUL_CW = $clog2(MBW);
   localparam int SQ_CW  = $clog2(DW);
   localparam int DIV_CW = $clog2(NUMW);

   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   localparam int CSR_AW = 5;

   localparam logic [ESW-1:0] ENERGY_CAP    = '1;
   localparam logic [QW-1:0]  FORCE_CAP_POS = QW'(64'h7FFF_FFFF);
   localparam logic [QW-1:0]  FORCE_CAP_NEG = QW'(64'h8000_0000);
   localparam logic [30:0]    RADIUS_RESET  = 31'(64'd1 << FRAC_BITS);
   localparam logic [31:0]    GAIN_RESET    = 32'(64'd1 << FRAC_BITS);

   typedef enum logic [2:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_CENTER_Z = 3'd2,
      REG_RADIUS   = 3'd3,
      REG_GAIN     = 3'd4
   } sbp_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_ROOT, ST_DSQ, ST_EGAIN, ST_EMASS,
      ST_FGAIN, ST_FMASS, ST_FVEC, ST_DIV, ST_OUT
   } sbp_state_type;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0]        radius;
      logic [31:0]        gain;
   } sbp_cfg_type;

   typedef struct packed {
      logic [DIMENSIONS-1:0][VW-1:0] vmag;
      logic [DIMENSIONS-1:0]         vneg;
      logic [31:0]                   mass;
      logic                          last;
   } sbp_item_type;

   typedef struct packed {
      logic push;
      logic full;
   } sbp_qctl_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic [ESW-1:0]     energy_total;
      logic               energy_valid;
      logic               saturated;
   } sbp_result_type;

endpackage

>>> sv/sbp_if.sv
interface sbp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [31:0]        particle_mass;
   logic               last_particle;

   modport source (output valid, pos_x, pos_y, pos_z, particle_mass, last_particle,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, particle_mass, last_particle,
                   output ready);
endinterface

interface sbp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] force_x;
   logic signed [31:0] force_y;
   logic signed [31:0] force_z;
   logic [62:0]        energy_total;
   logic               energy_valid;
   logic               saturated;

   modport source (output valid, force_x, force_y, force_z, energy_total, energy_valid,
                   saturated, input ready);
   modport sink   (input valid, force_x, force_y, force_z, energy_total, energy_valid,
                   saturated, output ready);
endinterface

>>> sv/sbp_front.sv
module sbp_front (
   sbp_req_if.sink               req_bus,
   input  sbp_pkg::sbp_cfg_type  cfg,
   input  logic                  q_full,
   output sbp_pkg::sbp_qctl_type qctl,
   output sbp_pkg::sbp_item_type item
);
   import sbp_pkg::*;

   logic [DIMENSIONS-1:0][31:0] pos;
   logic [DIMENSIONS-1:0][31:0] cen;
   logic [DIMENSIONS-1:0][VW:0] diff;

   assign pos = {req_bus.pos_z, req_bus.pos_y, req_bus.pos_x};
   assign cen = {cfg.center_z, cfg.center_y, cfg.center_x};

   // offset from the centre as sign and magnitude, one spare bit for the sign
   always_comb begin
      for (int i = 0; i < DIMENSIONS; i++) begin
         diff[i]      = {{2{pos[i][31]}}, pos[i]} - {{2{cen[i][31]}}, cen[i]};
         item.vneg[i] = diff[i][VW];
         item.vmag[i] = diff[i][VW] ? VW'(~diff[i] + 1'b1) : diff[i][VW-1:0];
      end
   end

   assign item.mass     = req_bus.particle_mass;
   assign item.last     = req_bus.last_particle;
   assign req_bus.ready = !q_full;
   assign qctl.full     = q_full;
   assign qctl.push     = req_bus.valid && !q_full;
endmodule

>>> sv/sbp_queue.sv
module sbp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  sbp_pkg::sbp_qctl_type qctl,
   input  sbp_pkg::sbp_item_type wr_item,
   input  logic                  pop,
   output sbp_pkg::sbp_item_type rd_item,
   output logic                  full,
   output logic                  not_empty
);
   import sbp_pkg::*;

   sbp_item_type           mem_ff [QDEPTH];
   logic [QPW-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]         count_ff, count_in;

   assign full      = (count_ff == QCW'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = qctl.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCW'(qctl.push) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (qctl.push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

>>> sv/sbp_mul.sv
module sbp_mul (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [sbp_pkg::MAW-1:0] a,
   input  logic [sbp_pkg::MBW-1:0] b,
   output logic                    done,
   output logic [sbp_pkg::PW-1:0]  prod
);
   import sbp_pkg::*;

   logic [PW-1:0]     p_ff, p_in;
   logic [MAW-1:0]    a_ff, a_in;
   logic [MUL_CW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [MAW:0]      sum;

   // one multiplier bit a cycle, product shifts right into the low half
   always_comb begin
      sum     = {1'b0, p_ff[PW-1:MBW]} + (p_ff[0] ? {1'b0, a_ff} : '0);
      p_in    = p_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         p_in    = {{MAW{1'b0}}, b};
         a_in    = a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in   = {sum, p_ff[MBW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CW'(MBW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      a_ff   <= a_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = p_ff;
endmodule

>>> sv/sbp_sqrt.sv
module sbp_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [sbp_pkg::SW-1:0] rad,
   output logic                   done,
   output logic [sbp_pkg::DW-1:0] root
);
   import sbp_pkg::*;

   logic [SW-1:0]    rad_ff, rad_in;
   logic [RW-1:0]    rem_ff, rem_in, rem2, trial;
   logic [DW-1:0]    root_ff, root_in;
   logic [SQ_CW-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   // digit-by-digit floor root, two radicand bits a cycle
   always_comb begin
      rem2    = {rem_ff[RW-3:0], rad_ff[SW-1:SW-2]};
      trial   = {1'b0, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SW-3:0], 2'b00};
         if (rem2 >= trial) begin
            rem_in  = rem2 - trial;
            root_in = {root_ff[DW-2:0], 1'b1};
         end else begin
            rem_in  = rem2;
            root_in = {root_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

>>> sv/sbp_div.sv
module sbp_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [sbp_pkg::NUMW-1:0] num,
   input  logic [sbp_pkg::DW-1:0]   den,
   output logic                     done,
   output logic [sbp_pkg::QW-1:0]   quo,
   output logic                     ovf
);
   import sbp_pkg::*;

   logic [NUMW-1:0]   num_ff, num_in;
   logic [DW-1:0]     den_ff, den_in, rem_ff, rem_in;
   logic [DW:0]       rem2;
   logic [QW-1:0]     q_ff, q_in;
   logic              ovf_ff, ovf_in, ge;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   // restoring division, one quotient bit a cycle; bits that fall off the top stick in ovf
   always_comb begin
      rem2    = {rem_ff, num_ff[NUMW-1]};
      ge      = (rem2 >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         q_in    = '0;
         ovf_in  = 1'b0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUMW-2:0], 1'b0};
         rem_in = ge ? DW'(rem2 - {1'b0, den_ff}) : rem2[DW-1:0];
         q_in   = {q_ff[QW-2:0], ge};
         ovf_in = ovf_ff | q_ff[QW-1];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(NUMW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign ovf  = ovf_ff;
endmodule

>>> sv/sbp_back.sv
module sbp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  sbp_pkg::sbp_cfg_type    cfg,
   input  sbp_pkg::sbp_item_type   q_item,
   input  logic                    q_valid,
   output logic                    pop,
   output sbp_pkg::sbp_result_type res,
   output logic                    res_valid,
   input  logic                    res_ready
);
   import sbp_pkg::*;

   sbp_state_type state_ff, state_in;
   logic          launched_ff, launched_in;
   logic [IDXW-1:0] idx_ff, idx_in;
   sbp_item_type  item_ff, item_in;
   logic [SW-1:0] s_ff, s_in;
   logic [DW-1:0] norm_ff, norm_in, dmag_ff, dmag_in;
   logic          dneg_ff, dneg_in;
   logic [BASEW-1:0] base_ff, base_in;
   logic [DIMENSIONS-1:0][31:0] force_ff, force_in;
   logic [ESW-1:0] esum_ff, esum_in;
   logic          sat_ff, sat_in;

   logic          mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done, div_ovf;
   logic [MAW-1:0] mul_a;
   logic [MBW-1:0] mul_b;
   logic [PW-1:0]  mul_p;
   logic [DW-1:0]  root;
   logic [QW-1:0]  quo;
   logic           unit_done, last_dim;

   logic [PW+63:0] e_wide;
   logic [ESW-1:0] e_val;
   logic           e_over;
   logic [ESW:0]   e_sum;
   logic           f_neg, f_over;
   logic [QW-1:0]  f_cap, f_mag;

   sbp_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(mul_p)
   );

   sbp_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .rad(s_ff),
      .done(sqrt_done), .root(root)
   );

   sbp_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(mul_p[NUMW-1:0]),
      .den(norm_ff), .done(div_done), .quo(quo), .ovf(div_ovf)
   );

   assign last_dim = (idx_ff == IDXW'(DIMENSIONS - 1));

   always_comb begin
      case (state_ff)
         ST_ROOT: unit_done = sqrt_done;
         ST_DIV:  unit_done = div_done;
         default: unit_done = mul_done;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (q_valid) state_in = ST_SQUARE;
         ST_SQUARE: if (unit_done && last_dim) state_in = ST_ROOT;
         ST_ROOT:   if (unit_done) state_in = ST_DSQ;
         ST_DSQ:    if (unit_done) state_in = ST_EGAIN;
         ST_EGAIN:  if (unit_done) state_in = ST_EMASS;
         ST_EMASS:  if (unit_done) state_in = ST_FGAIN;
         ST_FGAIN:  if (unit_done) state_in = ST_FMASS;
         ST_FMASS:  if (unit_done) state_in = (norm_ff == '0) ? ST_OUT : ST_FVEC;
         ST_FVEC:   if (unit_done) state_in = ST_DIV;
         ST_DIV:    if (unit_done) state_in = last_dim ? ST_OUT : ST_FVEC;
         ST_OUT:    if (res_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // energy term and force clamp from the unit results
   always_comb begin
      e_wide = {64'd0, mul_p} >> (2 * FRAC_BITS + 1);
      e_over = |e_wide[PW+63:ESW];
      e_val  = e_over ? ENERGY_CAP : e_wide[ESW-1:0];
      e_sum  = {1'b0, esum_ff} + {1'b0, e_val};
      f_neg  = (dneg_ff == item_ff.vneg[idx_ff]);
      f_cap  = f_neg ? FORCE_CAP_NEG : FORCE_CAP_POS;
      f_over = div_ovf || (quo > f_cap);
      f_mag  = f_over ? f_cap : quo;
   end

   // outputs and datapath
   always_comb begin
      pop         = 1'b0;
      res_valid   = 1'b0;
      mul_start   = 1'b0;
      sqrt_start  = 1'b0;
      div_start   = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      launched_in = launched_ff;
      idx_in      = idx_ff;
      item_in     = item_ff;
      s_in        = s_ff;
      norm_in     = norm_ff;
      dmag_in     = dmag_ff;
      dneg_in     = dneg_ff;
      base_in     = base_ff;
      force_in    = force_ff;
      esum_in     = esum_ff;
      sat_in      = sat_ff;

      unique case (state_ff)
         ST_SQUARE, ST_FVEC: begin
            mul_a = MAW'(state_ff == ST_FVEC ? VW'(base_ff) : item_ff.vmag[idx_ff]);
            mul_a = (state_ff == ST_FVEC) ? MAW'(base_ff) : MAW'(item_ff.vmag[idx_ff]);
            mul_b = MBW'(item_ff.vmag[idx_ff]);
         end
         ST_DSQ: begin
            mul_a = MAW'(dmag_ff);
            mul_b = MBW'(dmag_ff);
         end
         ST_EGAIN: begin
            mul_a = MAW'(mul_p[2*DW-1:FRAC_BITS]);
            mul_b = MBW'(cfg.gain);
         end
         ST_EMASS: begin
            mul_a = mul_p[MAW-1:0];
            mul_b = MBW'(item_ff.mass);
         end
         ST_FGAIN: begin
            mul_a = MAW'(dmag_ff);
            mul_b = MBW'(cfg.gain);
         end
         ST_FMASS: begin
            mul_a = MAW'(mul_p[DW+31:0]);
            mul_b = MBW'(item_ff.mass);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop         = 1'b1;
               item_in     = q_item;
               s_in        = '0;
               idx_in      = '0;
               launched_in = 1'b0;
            end
         end
         ST_ROOT: begin
            sqrt_start  = !launched_ff;
            launched_in = 1'b1;
            if (sqrt_done) begin
               launched_in = 1'b0;
               norm_in     = root;
               dneg_in     = (root < {2'b00, cfg.radius});
               dmag_in     = (root < {2'b00, cfg.radius}) ? ({2'b00, cfg.radius} - root)
                                                          : (root - {2'b00, cfg.radius});
            end
         end
         ST_DIV: begin
            div_start   = !launched_ff;
            launched_in = 1'b1;
            if (div_done) begin
               launched_in      = 1'b0;
               force_in[idx_ff] = f_neg ? 32'(~f_mag + 1'b1) : 32'(f_mag);
               sat_in           = sat_ff | f_over;
               idx_in           = last_dim ? '0 : idx_ff + 1'b1;
            end
         end
         ST_OUT: begin
            res_valid = 1'b1;
            if (res_ready && item_ff.last) begin
               esum_in = '0;
               sat_in  = 1'b0;
            end
         end
         default: begin
            // multiplier steps
            mul_start   = !launched_ff;
            launched_in = 1'b1;
            if (mul_done) begin
               launched_in = 1'b0;
               case (state_ff)
                  ST_SQUARE: begin
                     s_in   = s_ff + mul_p[SW-1:0];
                     idx_in = last_dim ? '0 : idx_ff + 1'b1;
                  end
                  ST_EMASS: begin
                     if (e_sum[ESW]) begin
                        esum_in = ENERGY_CAP;
                        sat_in  = 1'b1;
                     end else begin
                        esum_in = e_sum[ESW-1:0];
                        sat_in  = sat_ff | e_over;
                     end
                  end
                  ST_FMASS: begin
                     base_in = mul_p[DW+63:2*FRAC_BITS];
                     idx_in  = '0;
                     if (norm_ff == '0) begin
                        force_in = '0;
                     end
                  end
                  default: begin
                     idx_in = idx_ff;
                  end
               endcase
            end
         end
      endcase
   end

   assign res.force_x      = force_ff[0];
   assign res.force_y      = force_ff[1];
   assign res.force_z      = force_ff[2];
   assign res.energy_total = item_ff.last ? esum_ff : '0;
   assign res.energy_valid = item_ff.last;
   assign res.saturated    = sat_ff;

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      s_ff     <= s_in;
      norm_ff  <= norm_in;
      dmag_ff  <= dmag_in;
      dneg_ff  <= dneg_in;
      base_ff  <= base_in;
      force_ff <= force_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         launched_ff <= 1'b0;
         esum_ff     <= '0;
         sat_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
         esum_ff     <= esum_in;
         sat_ff      <= sat_in;
      end
   end
endmodule

>>> sv/sphere_barrier_penalty.sv
// spherical barrier penalty for a particle stream, signed Q16.16 fixed point
// req_bus: one beat per particle (position, mass, last flag), valid/ready
// rsp_bus: one beat per particle (force vector, energy total, flags)
// registers: centre x/y/z, radius and gain on a simple APB-style port,
//   word-aligned, written in the access cycle, pready tied high
// per particle the back end runs eleven serial multiplies, one floor square root
//   and three divides, and skips the three force multiplies and the divides
//   when the particle sits on the centre
// the serial multiplier, the serial square root and the bit-a-cycle divider set the rate
// a two-beat queue parts the front from the back, so a new particle can be
//   taken while the back end is busy and an output beat still waits
// when rsp_bus stalls, the result sits in the output register, the back end
//   parks holding its next result and the queue fills, then req_bus.ready drops
// reset clears the energy sum, the sticky saturation flag, the queue and the
//   output valid flag, and returns the registers to centre 0, radius 1.0, gain 1.0
// the saturation flag is reported on every beat; it and the energy sum are cleared on the last beat
`include "assert_macros.svh"

module sphere_barrier_penalty (
   input  logic                       clock,
   input  logic                       reset,
   sbp_req_if.sink                    req_bus,
   sbp_rsp_if.source                  rsp_bus,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sbp_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import sbp_pkg::*;

   // configuration registers
   logic signed [31:0] center_x_ff, center_x_in;
   logic signed [31:0] center_y_ff, center_y_in;
   logic signed [31:0] center_z_ff, center_z_in;
   logic [30:0]        radius_ff, radius_in;
   logic [31:0]        gain_ff, gain_in;
   sbp_reg_type        reg_idx;
   logic               wr_en;
   sbp_cfg_type        cfg;

   // front, queue and back end
   sbp_qctl_type   qctl;
   sbp_item_type   front_item, q_item;
   logic           q_full, q_valid, pop;
   sbp_result_type res;
   logic           res_valid, res_ready;

   // output register
   sbp_result_type rsp_data_ff, rsp_data_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign pready  = 1'b1;
   assign reg_idx = sbp_reg_type'(paddr[CSR_AW-1:2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      center_z_in = center_z_ff;
      radius_in   = radius_ff;
      gain_in     = gain_ff;
      prdata      = '0;
      unique case (reg_idx)
         REG_CENTER_X: begin
            prdata = center_x_ff;
            if (wr_en) center_x_in = pwdata;
         end
         REG_CENTER_Y: begin
            prdata = center_y_ff;
            if (wr_en) center_y_in = pwdata;
         end
         REG_CENTER_Z: begin
            prdata = center_z_ff;
            if (wr_en) center_z_in = pwdata;
         end
         REG_RADIUS: begin
            prdata = {1'b0, radius_ff};
            if (wr_en) radius_in = pwdata[30:0];
         end
         REG_GAIN: begin
            prdata = gain_ff;
            if (wr_en) gain_in = pwdata;
         end
         default: begin
            // unlisted addresses read zero and ignore writes
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= RADIUS_RESET;
         gain_ff     <= GAIN_RESET;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         center_z_ff <= center_z_in;
         radius_ff   <= radius_in;
         gain_ff     <= gain_in;
      end
   end

   assign cfg.center_x = center_x_ff;
   assign cfg.center_y = center_y_ff;
   assign cfg.center_z = center_z_ff;
   assign cfg.radius   = radius_ff;
   assign cfg.gain     = gain_ff;

   // front: offset from the centre, straight into the queue
   sbp_front u_front (
      .req_bus(req_bus), .cfg(cfg), .q_full(q_full), .qctl(qctl), .item(front_item)
   );

   sbp_queue u_queue (
      .clock(clock), .reset(reset), .qctl(qctl), .wr_item(front_item), .pop(pop),
      .rd_item(q_item), .full(q_full), .not_empty(q_valid)
   );

   // back: norm, distance, energy and force through the shared serial units
   sbp_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .q_item(q_item), .q_valid(q_valid),
      .pop(pop), .res(res), .res_valid(res_valid), .res_ready(res_ready)
   );

   // output register, loads whenever the slot is free or being emptied
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_data_in  = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.force_x      = rsp_data_ff.force_x;
   assign rsp_bus.force_y      = rsp_data_ff.force_y;
   assign rsp_bus.force_z      = rsp_data_ff.force_z;
   assign rsp_bus.energy_total = rsp_data_ff.energy_total;
   assign rsp_bus.energy_valid = rsp_data_ff.energy_valid;
   assign rsp_bus.saturated    = rsp_data_ff.saturated;

   // a beat without the energy flag never carries a total
   `SBP_ASSERT(a_energy_gated, rsp_bus.valid && !rsp_bus.energy_valid |-> rsp_bus.energy_total == '0, "energy total on a beat without energy_valid")
   // a result handed over by the back end shows on the port next cycle
   `SBP_ASSERT(a_handoff, res_valid && res_ready |=> rsp_bus.valid, "handed-over result missing from output")
   `SBP_ASSERT_NEVER(a_pop_empty, pop && !q_valid, "queue popped while empty")
endmodule
